// ===== hw/rtl/fssu_pkg.sv =====
// shared types, constants and helpers for the seven-segment scanner
// no dependencies
package fssu_pkg;

   localparam int VALUE_W             = 32;
   localparam int DIGIT_W             = 4;
   localparam int SHOWN_DIGITS        = 4;
   localparam int BCD_W               = SHOWN_DIGITS * DIGIT_W;
   localparam int SEG_W               = 7;
   localparam int PERIOD_W            = 8;
   localparam int STEP_W              = $clog2(VALUE_W);
   localparam int DIGIT_COUNT_DEFAULT = 4;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_INDEX_W         = 1;
   localparam int CSR_DATA_W          = 8;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd250;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INVERT       = 1'b0,
      CSR_BLINK_PERIOD = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                invert;
      logic [PERIOD_W-1:0] blink_period;
   } cfg_type;

   function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] pattern;
      unique case (digit)
         4'd0:    pattern = 7'h3F;
         4'd1:    pattern = 7'h06;
         4'd2:    pattern = 7'h5B;
         4'd3:    pattern = 7'h4F;
         4'd4:    pattern = 7'h66;
         4'd5:    pattern = 7'h6D;
         4'd6:    pattern = 7'h7D;
         4'd7:    pattern = 7'h07;
         4'd8:    pattern = 7'h7F;
         4'd9:    pattern = 7'h6F;
         default: pattern = 7'h00;
      endcase
      return pattern;
   endfunction

   // add three to every decimal digit of five or more before the shift
   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] result;
      result = bcd;
      for (int i = 0; i < SHOWN_DIGITS; i++) begin
         if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            result[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/fssu_front.sv =====
// front end: accepts scan-tick beats into a two-entry value queue
// depends on fssu_pkg
module fssu_front
   import fssu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_display_value,
   output logic               q_valid,
   input  logic               q_ready,
   output logic [VALUE_W-1:0] q_value
);

   localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountW = $clog2(QUEUE_DEPTH + 1);

   logic [VALUE_W-1:0] queue_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic               push, pop;

   assign req_ready = (count_ff != CountW'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_value   = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= req_display_value;
      end
   end

endmodule

// ===== hw/rtl/fssu_back.sv =====
// back end: scan state, segment drive, result register and the
// shift-and-add-three decimal conversion; depends on fssu_pkg
module fssu_back
   import fssu_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_valid,
   output logic               q_ready,
   input  logic [VALUE_W-1:0] q_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_digit_enable,
   output logic [SEG_W-1:0]   rsp_segment_lines,
   output logic               rsp_point_line
);

   localparam int ScanW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_CONV = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [ScanW-1:0]      scan_ff, scan_in;
   logic [PERIOD_W-1:0]   blink_ff, blink_in;
   logic                  point_ff, point_in;
   logic [DIGIT_W-1:0]    digits_ff [SHOWN_DIGITS];
   logic [DIGIT_W-1:0]    digits_in [SHOWN_DIGITS];
   logic [VALUE_W-1:0]    val_ff, val_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [3:0]            enable_ff, enable_in;
   logic [SEG_W-1:0]      seg_ff, seg_in;
   logic                  pt_ff, pt_in;

   logic                  out_free, start, last_step;
   logic [ScanW+1:0]      scan_ext;
   logic [1:0]            pos;
   logic [DIGIT_W-1:0]    digit;
   logic                  point_next;
   logic [PERIOD_W:0]     blink_sum;
   logic [SEG_W-1:0]      seg_raw;
   logic [BCD_W-1:0]      bcd_adj, bcd_step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign start     = (state_ff == ST_IDLE) && q_valid && out_free;
   assign q_ready   = start;
   assign last_step = (step_ff == STEP_W'(VALUE_W - 1));

   assign scan_ext   = {2'b00, scan_ff};
   assign pos        = scan_ext[1:0];
   assign digit      = digits_ff[pos];
   assign point_next = point_ff ^ (blink_ff == '0);
   assign blink_sum  = {1'b0, blink_ff} + (PERIOD_W + 1)'(1);
   assign seg_raw    = seg_pattern(digit);
   assign bcd_adj    = bcd_adjust(bcd_ff);
   assign bcd_step   = {bcd_adj[BCD_W-2:0], val_ff[VALUE_W-1]};

   assign enable_in = ~(4'(1) << pos);
   assign seg_in    = cfg.invert ? ~seg_raw : seg_raw;
   assign pt_in     = ((pos == 2'd1) && point_next) ^ cfg.invert;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (last_step) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      scan_in  = scan_ff;
      blink_in = blink_ff;
      point_in = point_ff;
      val_in   = val_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      for (int i = 0; i < SHOWN_DIGITS; i++) begin
         digits_in[i] = digits_ff[i];
      end
      if (start) begin
         point_in = point_next;
         blink_in = (blink_sum >= {1'b0, cfg.blink_period}) ? '0 : blink_sum[PERIOD_W-1:0];
         scan_in  = (scan_ff == ScanW'(DIGIT_COUNT - 1)) ? '0 : scan_ff + ScanW'(1);
         val_in   = q_value;
         bcd_in   = '0;
         step_in  = '0;
      end else if (state_ff == ST_CONV) begin
         val_in  = val_ff << 1;
         bcd_in  = bcd_step;
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            // first digit is the thousands
            for (int i = 0; i < SHOWN_DIGITS; i++) begin
               digits_in[i] = bcd_step[(SHOWN_DIGITS - 1 - i)*DIGIT_W +: DIGIT_W];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (start) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         blink_ff     <= '0;
         point_ff     <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SHOWN_DIGITS; i++) begin
            digits_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         blink_ff     <= blink_in;
         point_ff     <= point_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < SHOWN_DIGITS; i++) begin
            digits_ff[i] <= digits_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      bcd_ff <= bcd_in;
      if (start) begin
         enable_ff <= enable_in;
         seg_ff    <= seg_in;
         pt_ff     <= pt_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_digit_enable  = enable_ff;
   assign rsp_segment_lines = seg_ff;
   assign rsp_point_line    = pt_ff;

endmodule

// ===== hw/rtl/four_digit_seven_segment_scanner_unit.sv =====
// top level of the multiplexed four-digit seven-segment scanner
// depends on fssu_pkg, fssu_front and fssu_back
//
// Each req beat is one scan tick carrying a 32-bit value. The rsp beat for a
// tick drives one digit (its enable low) with the a-g pattern and point of
// the digits stored by the previous tick; the value's low four decimal
// digits are then stored for the next tick.
// The csr channel writes register 0 (segment and point inversion) and
// register 1 (blink period in ticks); csr_ready is always high. The user must
// make writes only while no tick is in flight; the block does not enforce it.
// A req beat is first written into the front queue; when the back end is idle
// and the result register is free, it is issued and its result registered.
// The back end takes the next tick only after the decimal conversion, which
// follows the issue and shifts one value bit per cycle through all 32 bits.
// The front queue holds two further ticks meanwhile.
// A stalled rsp beat holds its payload; the back end waits with the next tick
// until the result register is free, and req_ready drops once the queue is
// full.
// Reset clears the stored digits to zero, the scan index, blink count and
// point, and loads inversion on and a blink period of 250.
module four_digit_seven_segment_scanner_unit
   import fssu_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_W-1:0]     req_display_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_digit_enable,
   output logic [SEG_W-1:0]       rsp_segment_lines,
   output logic                   rsp_point_line
);

   logic                invert_ff, invert_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   cfg_type             cfg;
   logic                q_valid, q_ready;
   logic [VALUE_W-1:0]  q_value;

   assign csr_ready = 1'b1;

   always_comb begin
      invert_in = invert_ff;
      period_in = period_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_INVERT:       invert_in = csr_wdata[0];
            CSR_BLINK_PERIOD: period_in = csr_wdata[PERIOD_W-1:0];
            default:          invert_in = invert_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b1;
         period_ff <= PERIOD_RESET;
      end else begin
         invert_ff <= invert_in;
         period_ff <= period_in;
      end
   end

   assign cfg.invert       = invert_ff;
   assign cfg.blink_period = period_ff;

   fssu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_display_value (req_display_value),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_value           (q_value)
   );

   fssu_back #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_value           (q_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_digit_enable  (rsp_digit_enable),
      .rsp_segment_lines (rsp_segment_lines),
      .rsp_point_line    (rsp_point_line)
   );

endmodule

// ===== hw/rtl/fssu_checker.sv =====
// port-level checks for the seven-segment scanner, bound to the top level
// depends on fssu_pkg and four_digit_seven_segment_scanner_unit
module fssu_checker
   import fssu_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_wdata,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [3:0]             rsp_digit_enable,
   input logic [SEG_W-1:0]       rsp_segment_lines,
   input logic                   rsp_point_line
);

   logic invert_ff, invert_in;

   // shadow of the inversion register as seen on the csr channel
   always_comb begin
      invert_in = invert_ff;
      if (csr_valid && csr_ready && (csr_index_type'(csr_index) == CSR_INVERT)) begin
         invert_in = csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b1;
      end else begin
         invert_ff <= invert_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit_enable)
         && $stable(rsp_segment_lines) && $stable(rsp_point_line))
      else $error("rsp beat changed while stalled");

   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(~rsp_digit_enable))
      else $error("digit enable does not select exactly one digit");

   a_point_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_digit_enable != ~4'b0010) |-> rsp_point_line == invert_ff)
      else $error("point driven on a digit other than the second");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat valid right after reset");

endmodule

bind four_digit_seven_segment_scanner_unit fssu_checker u_checker (.*);

// ===== dv/four_digit_seven_segment_scanner_unit_tb.sv =====
// testbench for the four-digit seven-segment scanner: directed and random scan ticks,
// register writes and back-pressure, each rsp beat checked against an in-bench display model
// depends on fssu_pkg and four_digit_seven_segment_scanner_unit
module four_digit_seven_segment_scanner_unit_tb;
   import fssu_pkg::*;

   localparam int SCAN_DIGITS  = DIGIT_COUNT_DEFAULT;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SETTLE_TICKS = 40;

   localparam logic [SEG_W-1:0] DIGIT_GLYPHS [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   typedef struct packed {
      logic [3:0]       digit_enable;
      logic [SEG_W-1:0] segment_lines;
      logic             point_line;
   } display_drive_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic [VALUE_W-1:0]     req_display_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [3:0]             rsp_digit_enable;
   logic [SEG_W-1:0]       rsp_segment_lines;
   logic                   rsp_point_line;

   // display model state
   logic                invert_on;
   logic [PERIOD_W-1:0] blink_period;
   logic [PERIOD_W-1:0] blink_count;
   logic                point_on;
   int                  scan_pos;
   logic [DIGIT_W-1:0]  stored_digits [SHOWN_DIGITS];

   display_drive_type display_drives [$];

   int failures;
   int cycle_count;
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_off_len;
   int hold_off_seq;
   int hold_off_seen;
   int hold_off_left;

   four_digit_seven_segment_scanner_unit #(.DIGIT_COUNT(SCAN_DIGITS)) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_display_value (req_display_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_digit_enable  (rsp_digit_enable),
      .rsp_segment_lines (rsp_segment_lines),
      .rsp_point_line    (rsp_point_line)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_display_model();
      invert_on    = 1'b1;
      blink_period = PERIOD_RESET;
      blink_count  = '0;
      point_on     = 1'b0;
      scan_pos     = 0;
      for (int i = 0; i < SHOWN_DIGITS; i++) begin
         stored_digits[i] = '0;
      end
   endfunction

   // one scan tick: drive the stored digit, then latch the new value's low decimal digits
   function automatic void advance_display(input logic [VALUE_W-1:0] value);
      display_drive_type drive;
      logic [PERIOD_W:0] next_count;
      logic [VALUE_W-1:0] rest;
      int pos;
      pos = scan_pos % 4;
      if (blink_count == '0) begin
         point_on = ~point_on;
      end
      drive.digit_enable  = ~(4'b0001 << pos);
      drive.segment_lines = DIGIT_GLYPHS[stored_digits[pos]];
      drive.point_line    = (pos == 1) ? point_on : 1'b0;
      if (invert_on) begin
         drive.segment_lines = ~drive.segment_lines;
         drive.point_line    = ~drive.point_line;
      end
      display_drives.push_back(drive);
      next_count  = {1'b0, blink_count} + 1'b1;
      blink_count = (next_count >= {1'b0, blink_period}) ? '0 : next_count[PERIOD_W-1:0];
      scan_pos    = (scan_pos + 1 >= SCAN_DIGITS) ? 0 : scan_pos + 1;
      rest = value % 10000;
      for (int i = SHOWN_DIGITS - 1; i >= 0; i--) begin
         stored_digits[i] = DIGIT_W'(rest % 10);
         rest = rest / 10;
      end
   endfunction

   task automatic send_tick(input logic [VALUE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_display_value <= value;
      do @(posedge clock); while (!req_ready);
      advance_display(value);
   endtask

   task automatic drain_display();
      @(negedge clock);
      req_valid <= 1'b0;
      while (display_drives.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      drain_display();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INVERT:       invert_on    = data[0];
         CSR_BLINK_PERIOD: blink_period = data[PERIOD_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int sender_pct, input int stall_pct);
      @(negedge clock);
      req_valid          <= 1'b0;
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = stall_pct;
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] value;
      case ($urandom_range(3))
         0:       value = $urandom_range(9999);
         1:       value = 10000 * $urandom_range(429496) + $urandom_range(9);
         2:       value = 32'hFFFF_FFFF - $urandom_range(20000);
         default: value = $urandom;
      endcase
      return value;
   endfunction

   task automatic randomise_registers();
      logic [PERIOD_W-1:0] period;
      case ($urandom_range(5))
         0:       period = 8'd0;
         1:       period = 8'd1;
         2:       period = 8'd255;
         default: period = PERIOD_W'($urandom_range(2, 16));
      endcase
      write_register(CSR_INVERT, CSR_DATA_W'($urandom));
      write_register(CSR_BLINK_PERIOD, period);
   endtask

   task automatic test_power_on_digits();
      send_tick(32'd1234);
      send_tick(32'd0);
   endtask

   task automatic test_value_extremes();
      write_register(CSR_INVERT, 8'h00);
      send_tick(32'hFFFF_FFFF);
      send_tick(32'd9999);
      send_tick(32'd10000);
      send_tick(32'd0);
      send_tick(32'd8888);
      send_tick(32'd5678);
      send_tick(32'd90);
   endtask

   task automatic test_register_writes();
      write_register(CSR_BLINK_PERIOD, 8'd1);
      repeat (3) send_tick(random_value());
      // zero period behaves as one
      write_register(CSR_BLINK_PERIOD, 8'd0);
      repeat (2) send_tick(random_value());
      // only bit 0 of the inversion write counts
      write_register(CSR_INVERT, 8'hFF);
      send_tick(32'd4321);
      write_register(CSR_INVERT, 8'hFE);
      send_tick(32'd7);
      write_register(CSR_BLINK_PERIOD, 8'd255);
      send_tick(32'd2468);
   endtask

   task automatic test_period_lowered();
      repeat (3) send_tick(random_value());
      // count now above the new period, so the next tick wraps it
      write_register(CSR_BLINK_PERIOD, 8'd3);
      repeat (3) send_tick(random_value());
   endtask

   task automatic test_receiver_hold_off();
      set_idling(0, 0);
      @(posedge clock);
      hold_off_len = 400;
      hold_off_seq++;
      repeat (10) send_tick(random_value());
      drain_display();
   endtask

   task automatic test_random_ticks(input int sender_pct, input int stall_pct, input int count);
      randomise_registers();
      set_idling(sender_pct, stall_pct);
      repeat (count / 2) send_tick(random_value());
      randomise_registers();
      repeat (count - count / 2) send_tick(random_value());
   endtask

   always @(negedge clock) begin
      if (hold_off_seq != hold_off_seen) begin
         hold_off_left = hold_off_len;
         hold_off_seen = hold_off_seq;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      display_drive_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (display_drives.size() == 0) begin
            $error("rsp beat with no tick outstanding");
            failures++;
         end else begin
            due = display_drives.pop_front();
            if (rsp_digit_enable !== due.digit_enable) begin
               $error("digit_enable mismatch: expected %h, actual %h",
                      due.digit_enable, rsp_digit_enable);
               failures++;
            end
            if (rsp_segment_lines !== due.segment_lines) begin
               $error("segment_lines mismatch: expected %h, actual %h",
                      due.segment_lines, rsp_segment_lines);
               failures++;
            end
            if (rsp_point_line !== due.point_line) begin
               $error("point_line mismatch: expected %h, actual %h",
                      due.point_line, rsp_point_line);
               failures++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      failures           = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_len       = 0;
      hold_off_seq       = 0;
      hold_off_seen      = 0;
      hold_off_left      = 0;
      reset              = 1'b1;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_valid          = 1'b0;
      req_display_value  = '0;
      rsp_ready          = 1'b0;
      clear_display_model();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_on_digits();
      test_value_extremes();
      test_register_writes();
      test_period_lowered();
      test_random_ticks(0, 0, 150);
      test_receiver_hold_off();
      test_random_ticks(65, 0, 150);
      test_random_ticks(0, 65, 150);
      test_random_ticks(7, 7, 150);

      drain_display();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (failures == 0 && display_drives.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
